/* rtl/chlg_pkg.sv */
// Package for the core hotplug level governor: widths, codes, reset values,
// shared structs and small helper functions.
// Depends on nothing; the RTL uses scoped names, the testbench imports it.
package chlg_pkg;

  // Fixed sizes of the block.
  localparam int NUM_CPUS     = 8;
  localparam int HISTORY_BITS = 8;
  localparam int CORE_W       = $clog2(NUM_CPUS + 1);

  // Field widths.
  localparam int KIND_W   = 3;
  localparam int FREQ_W   = 22;
  localparam int LIMIT_W  = 8;
  localparam int TASK_W   = 16;
  localparam int LOCK_W   = 3;
  localparam int LEVEL_W  = 2;
  localparam int DELTA_W  = 6;
  localparam int VERD_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 22;

  localparam logic [HISTORY_BITS-1:0] HIST_MAX = '1;

  // Word kinds on the sample channel.
  localparam logic [KIND_W-1:0] KIND_TICK        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DISPLAY_OFF = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DISPLAY_ON  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SUSPEND     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESUME      = 3'd4;

  // Tick verdicts.
  localparam logic [VERD_W-1:0] VERDICT_STAY = 2'd0;
  localparam logic [VERD_W-1:0] VERDICT_UP   = 2'd1;
  localparam logic [VERD_W-1:0] VERDICT_DOWN = 2'd2;

  // Levels with a name of their own.
  localparam logic [LEVEL_W-1:0] LEVEL_ALL  = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_HALF = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_TOP  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_UP_FREQUENCY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_FREQUENCY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UP_LIMIT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_LIMIT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UP_TASK_FLOOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_TASK_FLOOR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FEWEST_LOCK     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MOST_LOCK       = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [FREQ_W-1:0]  RST_UP_FREQUENCY    = 22'd1300000;
  localparam logic [FREQ_W-1:0]  RST_DOWN_FREQUENCY  = 22'd800000;
  localparam logic [LIMIT_W-1:0] RST_UP_LIMIT        = 8'd3;
  localparam logic [LIMIT_W-1:0] RST_DOWN_LIMIT      = 8'd3;
  localparam logic [TASK_W-1:0]  RST_UP_TASK_FLOOR   = 16'd8;
  localparam logic [TASK_W-1:0]  RST_DOWN_TASK_FLOOR = 16'd6;
  localparam logic [LOCK_W-1:0]  RST_LOCK_OFF        = 3'b111;

  typedef struct packed {
    logic [FREQ_W-1:0]  up_frequency;
    logic [FREQ_W-1:0]  down_frequency;
    logic [LIMIT_W-1:0] up_limit;
    logic [LIMIT_W-1:0] down_limit;
    logic [TASK_W-1:0]  up_task_floor;
    logic [TASK_W-1:0]  down_task_floor;
    logic [LOCK_W-1:0]  fewest_level_lock;
    logic [LOCK_W-1:0]  most_level_lock;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [FREQ_W-1:0] cluster0_freq;
    logic [FREQ_W-1:0] cluster1_freq;
    logic [TASK_W-1:0] runnable_tasks;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               level_changed;
    logic               adding_cores;
    logic [DELTA_W-1:0] core_delta;
    logic [VERD_W-1:0]  decision;
  } result_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]      level;
    logic [HISTORY_BITS-1:0] up_history;
    logic [HISTORY_BITS-1:0] down_history;
    logic                    display_on;
    logic                    suspended;
  } gov_state_t;

  // Online core count for a level.
  function automatic logic [CORE_W-1:0] cores_at(input logic [LEVEL_W-1:0] lvl);
    logic [CORE_W-1:0] n;
    case (lvl)
      2'd0:    n = CORE_W'(NUM_CPUS);
      2'd1:    n = CORE_W'(NUM_CPUS / 2);
      2'd2:    n = CORE_W'(2);
      default: n = CORE_W'(1);
    endcase
    return n;
  endfunction

  // Saturating history increment.
  function automatic logic [HISTORY_BITS-1:0] hist_inc(input logic [HISTORY_BITS-1:0] h);
    return (h == HIST_MAX) ? h : h + 1'b1;
  endfunction

endpackage

/* rtl/chlg_if.sv */
// Channel interfaces of the core hotplug level governor: sample words,
// result words and configuration writes, each with valid and ready.
// Depends on chlg_pkg for field widths.
interface chlg_in_if;
  logic                        valid;
  logic                        ready;
  logic [chlg_pkg::KIND_W-1:0] kind;
  logic [chlg_pkg::FREQ_W-1:0] cluster0_freq;
  logic [chlg_pkg::FREQ_W-1:0] cluster1_freq;
  logic [chlg_pkg::TASK_W-1:0] runnable_tasks;

  modport source (output valid, kind, cluster0_freq, cluster1_freq, runnable_tasks,
                  input ready);
  modport sink (input valid, kind, cluster0_freq, cluster1_freq, runnable_tasks,
                output ready);
endinterface

interface chlg_out_if;
  logic                         valid;
  logic                         ready;
  logic [chlg_pkg::LEVEL_W-1:0] level;
  logic                         level_changed;
  logic                         adding_cores;
  logic [chlg_pkg::DELTA_W-1:0] core_delta;
  logic [chlg_pkg::VERD_W-1:0]  decision;

  modport source (output valid, level, level_changed, adding_cores, core_delta, decision,
                  input ready);
  modport sink (input valid, level, level_changed, adding_cores, core_delta, decision,
                output ready);
endinterface

interface chlg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [chlg_pkg::CFG_IDX_W-1:0]  index;
  logic [chlg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/chlg_cfg_regs.sv */
// Configuration register file of the core hotplug level governor.
// Depends on chlg_pkg and the chlg_cfg_if interface.
module chlg_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  chlg_cfg_if.sink        cfg,
  output chlg_pkg::cfg_t  regs
);

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.up_frequency      <= chlg_pkg::RST_UP_FREQUENCY;
      regs.down_frequency    <= chlg_pkg::RST_DOWN_FREQUENCY;
      regs.up_limit          <= chlg_pkg::RST_UP_LIMIT;
      regs.down_limit        <= chlg_pkg::RST_DOWN_LIMIT;
      regs.up_task_floor     <= chlg_pkg::RST_UP_TASK_FLOOR;
      regs.down_task_floor   <= chlg_pkg::RST_DOWN_TASK_FLOOR;
      regs.fewest_level_lock <= chlg_pkg::RST_LOCK_OFF;
      regs.most_level_lock   <= chlg_pkg::RST_LOCK_OFF;
    end else if (cfg.valid) begin
      case (cfg.index)
        chlg_pkg::REG_UP_FREQUENCY: begin
          regs.up_frequency <= cfg.data[chlg_pkg::FREQ_W-1:0];
        end
        chlg_pkg::REG_DOWN_FREQUENCY: begin
          regs.down_frequency <= cfg.data[chlg_pkg::FREQ_W-1:0];
        end
        chlg_pkg::REG_UP_LIMIT: begin
          regs.up_limit <= cfg.data[chlg_pkg::LIMIT_W-1:0];
        end
        chlg_pkg::REG_DOWN_LIMIT: begin
          regs.down_limit <= cfg.data[chlg_pkg::LIMIT_W-1:0];
        end
        chlg_pkg::REG_UP_TASK_FLOOR: begin
          regs.up_task_floor <= cfg.data[chlg_pkg::TASK_W-1:0];
        end
        chlg_pkg::REG_DOWN_TASK_FLOOR: begin
          regs.down_task_floor <= cfg.data[chlg_pkg::TASK_W-1:0];
        end
        chlg_pkg::REG_FEWEST_LOCK: begin
          regs.fewest_level_lock <= cfg.data[chlg_pkg::LOCK_W-1:0];
        end
        chlg_pkg::REG_MOST_LOCK: begin
          regs.most_level_lock <= cfg.data[chlg_pkg::LOCK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/chlg_decide.sv */
// Decision logic of the core hotplug level governor: from the current state,
// the configuration and one word, the next state and the result word.
// Depends on chlg_pkg.
module chlg_decide (
  input  chlg_pkg::cfg_t      cfg,
  input  chlg_pkg::gov_state_t gs,
  input  chlg_pkg::item_t     item,
  output chlg_pkg::gov_state_t gs_next,
  output chlg_pkg::result_t   res
);

  logic                                c0_mid, c1_mid, mid_band;
  logic                                down_vote, up_vote;
  logic [chlg_pkg::HISTORY_BITS-1:0]   up_h, dn_h;
  logic [chlg_pkg::VERD_W-1:0]         verdict;
  logic [chlg_pkg::LEVEL_W-1:0]        target, level_inc, level_dec, new_level;
  logic                                req, forced, disp, susp, changed;
  logic signed [3:0]                   st, fewest4, most4;
  logic [chlg_pkg::CORE_W-1:0]         cores_old, cores_new;

  // Frequency classification of the two clusters.
  assign c0_mid = (item.cluster0_freq < cfg.up_frequency)
                  && (item.cluster0_freq > cfg.down_frequency);
  assign c1_mid = (item.cluster1_freq < cfg.up_frequency)
                  && (item.cluster1_freq > cfg.down_frequency);
  assign mid_band = c0_mid || c1_mid;
  assign down_vote = ((item.cluster0_freq <= cfg.down_frequency)
                      && (item.cluster1_freq <= cfg.down_frequency))
                     || (cfg.down_task_floor >= item.runnable_tasks);
  assign up_vote = (item.cluster0_freq >= cfg.up_frequency)
                   || (item.cluster1_freq >= cfg.up_frequency);

  assign level_inc = (gs.level == chlg_pkg::LEVEL_TOP) ? gs.level : gs.level + 1'b1;
  assign level_dec = (gs.level == chlg_pkg::LEVEL_ALL) ? gs.level : gs.level - 1'b1;

  assign fewest4 = {cfg.fewest_level_lock[chlg_pkg::LOCK_W-1], cfg.fewest_level_lock};
  assign most4   = {cfg.most_level_lock[chlg_pkg::LOCK_W-1], cfg.most_level_lock};

  assign cores_old = chlg_pkg::cores_at(gs.level);
  assign cores_new = chlg_pkg::cores_at(new_level);

  always_comb begin
    up_h    = gs.up_history;
    dn_h    = gs.down_history;
    verdict = chlg_pkg::VERDICT_STAY;
    target  = gs.level;
    req     = 1'b0;
    forced  = 1'b0;
    disp    = gs.display_on;
    susp    = gs.suspended;

    case (item.kind)
      chlg_pkg::KIND_TICK: begin
        if (mid_band) begin
          up_h = '0;
          dn_h = '0;
        end else begin
          if (down_vote) begin
            dn_h = chlg_pkg::hist_inc(gs.down_history);
            up_h = '0;
          end else if (up_vote) begin
            up_h = chlg_pkg::hist_inc(gs.up_history);
            dn_h = '0;
          end
          if (32'(up_h) > 32'(cfg.up_limit)) begin
            verdict = chlg_pkg::VERDICT_UP;
          end else if (32'(dn_h) > 32'(cfg.down_limit)) begin
            verdict = chlg_pkg::VERDICT_DOWN;
          end
        end
        if (verdict == chlg_pkg::VERDICT_DOWN) begin
          req    = 1'b1;
          target = level_inc;
        end else if (verdict == chlg_pkg::VERDICT_UP) begin
          req = 1'b1;
          // At half the cores, a light task load holds the level.
          if (gs.level == chlg_pkg::LEVEL_HALF
              && cfg.up_task_floor >= item.runnable_tasks) begin
            target = gs.level;
          end else begin
            target = level_dec;
          end
        end
      end
      chlg_pkg::KIND_DISPLAY_OFF: begin
        disp   = 1'b0;
        req    = 1'b1;
        target = level_inc;
      end
      chlg_pkg::KIND_DISPLAY_ON: begin
        disp   = 1'b1;
        req    = 1'b1;
        forced = 1'b1;
        target = chlg_pkg::LEVEL_HALF;
      end
      chlg_pkg::KIND_SUSPEND: begin
        susp = 1'b1;
        up_h = '0;
        dn_h = '0;
      end
      chlg_pkg::KIND_RESUME: begin
        susp = 1'b0;
      end
      default: begin
      end
    endcase

    // Display cap and the two level locks, skipped when the level is forced.
    st = signed'({2'b00, target});
    if (!forced) begin
      if (disp && st > 4'sd1) begin
        st = 4'sd1;
      end
      if (fewest4 >= 4'sd0 && st >= fewest4) begin
        st = fewest4;
      end
      if (most4 > 4'sd0 && st <= most4) begin
        st = most4;
      end
    end
    new_level = st[chlg_pkg::LEVEL_W-1:0];
    changed   = req && !gs.suspended && (new_level != gs.level);

    if (changed) begin
      up_h = '0;
      dn_h = '0;
    end

    gs_next.level        = changed ? new_level : gs.level;
    gs_next.up_history   = up_h;
    gs_next.down_history = dn_h;
    gs_next.display_on   = disp;
    gs_next.suspended    = susp;

    res.level         = gs_next.level;
    res.level_changed = changed;
    res.adding_cores  = changed && (gs.level > new_level);
    if (!changed) begin
      res.core_delta = '0;
    end else if (cores_old > cores_new) begin
      res.core_delta = chlg_pkg::DELTA_W'(cores_old - cores_new);
    end else begin
      res.core_delta = chlg_pkg::DELTA_W'(cores_new - cores_old);
    end
    res.decision = verdict;
  end

endmodule

/* rtl/core_hotplug_level_governor.sv */
// Top level of the core hotplug level governor: input register, governor
// state, result register and handshake control.
// Depends on chlg_pkg, the chlg interfaces, chlg_cfg_regs and chlg_decide.
//
//   Channel   Dir   Handshake      Contents of one word
//   samples   in    valid/ready    kind, cluster0_freq, cluster1_freq, runnable_tasks
//   results   out   valid/ready    level, level_changed, adding_cores, core_delta,
//                                  decision
//   cfg       in    valid/ready    register index, write data
//
// Every sample word yields exactly one result word. A word is captured in the
// input register; the decision logic works on it combinationally against the
// governor state, and the state and the result register update together when
// the result register advances. The block takes one word per cycle while the
// result channel is not stalled; nothing iterates.
// Reset is synchronous and active high: it restores the register defaults,
// puts the level at all cores with the display on, not suspended, and empties
// both pipeline registers. A stalled result register holds the input register,
// and a new word still enters whenever the input register is free.
module core_hotplug_level_governor (
  input  logic        clk,
  input  logic        rst,
  chlg_in_if.sink     samples,
  chlg_out_if.source  results,
  chlg_cfg_if.sink    cfg
);

  chlg_pkg::cfg_t       regs;
  chlg_pkg::item_t      item_q, item_in;
  chlg_pkg::gov_state_t gs, gs_next;
  chlg_pkg::result_t    res_q, res_next;
  logic                 item_valid;
  logic                 res_valid;
  logic                 advance;

  chlg_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  chlg_decide u_decide (
    .cfg     (regs),
    .gs      (gs),
    .item    (item_q),
    .gs_next (gs_next),
    .res     (res_next)
  );

  // The result register moves when it is empty or its word is being taken;
  // the input register refills whenever it empties into the result register.
  assign advance       = !res_valid || results.ready;
  assign samples.ready = !item_valid || advance;

  assign item_in.kind           = samples.kind;
  assign item_in.cluster0_freq  = samples.cluster0_freq;
  assign item_in.cluster1_freq  = samples.cluster1_freq;
  assign item_in.runnable_tasks = samples.runnable_tasks;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid      <= 1'b0;
      res_valid       <= 1'b0;
      gs.level        <= chlg_pkg::LEVEL_ALL;
      gs.up_history   <= '0;
      gs.down_history <= '0;
      gs.display_on   <= 1'b1;
      gs.suspended    <= 1'b0;
    end else begin
      if (samples.ready) begin
        item_valid <= samples.valid;
      end
      if (advance) begin
        res_valid <= item_valid;
        if (item_valid) begin
          gs <= gs_next;
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      item_q <= item_in;
    end
    if (advance && item_valid) begin
      res_q <= res_next;
    end
  end

  assign results.valid         = res_valid;
  assign results.level         = res_q.level;
  assign results.level_changed = res_q.level_changed;
  assign results.adding_cores  = res_q.adding_cores;
  assign results.core_delta    = res_q.core_delta;
  assign results.decision      = res_q.decision;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for core_hotplug_level_governor: sample, result and configuration
// channels are driven and watched, and each result word is checked against a level predictor.
// Depends on chlg_pkg, the chlg channel interfaces and the governor RTL.
module tb_top;
  import chlg_pkg::*;

  localparam logic [FREQ_W-1:0] FREQ_TOP = '1;
  localparam int TASK_TOP = (1 << TASK_W) - 1;

  // Keeps its own copy of the governor registers and state. Every accepted sample word
  // is turned into the result word the governor must return, and result words are
  // checked against those in order.
  class level_scoreboard;
    logic [FREQ_W-1:0]        up_freq, down_khz;
    logic [LIMIT_W-1:0]       up_limit, down_limit;
    logic [TASK_W-1:0]        up_task_floor, down_task_floor;
    logic signed [LOCK_W-1:0] fewest_lock, most_lock;
    logic [LEVEL_W-1:0]       level;
    logic [HISTORY_BITS-1:0]  up_hist, down_hist;
    bit                       display_on, suspended;
    result_t                  due_results[$];
    int failures, words, writes, moves, up_votes, down_votes, saturated;

    function new();
      up_freq         = RST_UP_FREQUENCY;
      down_khz        = RST_DOWN_FREQUENCY;
      up_limit        = RST_UP_LIMIT;
      down_limit      = RST_DOWN_LIMIT;
      up_task_floor   = RST_UP_TASK_FLOOR;
      down_task_floor = RST_DOWN_TASK_FLOOR;
      fewest_lock     = RST_LOCK_OFF;
      most_lock       = RST_LOCK_OFF;
      level           = LEVEL_ALL;
      up_hist         = '0;
      down_hist       = '0;
      display_on      = 1'b1;
      suspended       = 1'b0;
    endfunction

    function void note_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      writes++;
      case (idx)
        REG_UP_FREQUENCY:    up_freq = data[FREQ_W-1:0];
        REG_DOWN_FREQUENCY:  down_khz = data[FREQ_W-1:0];
        REG_UP_LIMIT:        up_limit = data[LIMIT_W-1:0];
        REG_DOWN_LIMIT:      down_limit = data[LIMIT_W-1:0];
        REG_UP_TASK_FLOOR:   up_task_floor = data[TASK_W-1:0];
        REG_DOWN_TASK_FLOOR: down_task_floor = data[TASK_W-1:0];
        REG_FEWEST_LOCK:     fewest_lock = data[LOCK_W-1:0];
        REG_MOST_LOCK:       most_lock = data[LOCK_W-1:0];
        default: ;
      endcase
    endfunction

    function int online_cores(logic [LEVEL_W-1:0] lvl);
      case (lvl)
        LEVEL_ALL:  return NUM_CPUS;
        LEVEL_HALF: return NUM_CPUS / 2;
        LEVEL_TOP:  return 1;
        default:    return 2;
      endcase
    endfunction

    // Applies the display cap and the two locks unless the move is forced, then
    // records the move in the result word.
    function void move_toward(int target, bit forced, inout result_t r);
      int st, fl, ml, was, now;
      logic [LEVEL_W-1:0] nl;
      if (suspended) return;
      st = target;
      fl = fewest_lock;
      ml = most_lock;
      if (!forced) begin
        if (display_on && st > int'(LEVEL_HALF)) st = LEVEL_HALF;
        if (fl >= 0 && st >= fl) st = fl;
        if (ml > 0 && st <= ml) st = ml;
      end
      nl = LEVEL_W'(st);
      if (nl == level) return;
      was = online_cores(level);
      now = online_cores(nl);
      r.level_changed = 1'b1;
      r.adding_cores  = (level > nl);
      r.core_delta    = DELTA_W'(was > now ? was - now : now - was);
      up_hist   = '0;
      down_hist = '0;
      level     = nl;
      moves++;
    endfunction

    function void note_word(item_t w);
      result_t r;
      logic [VERD_W-1:0] verdict;
      bit mid_band;
      int lvl;
      r = '0;
      verdict = VERDICT_STAY;
      lvl = level;
      words++;
      case (w.kind)
        KIND_TICK: begin
          mid_band = (w.cluster0_freq < up_freq && w.cluster0_freq > down_khz) ||
                     (w.cluster1_freq < up_freq && w.cluster1_freq > down_khz);
          if (mid_band) begin
            up_hist   = '0;
            down_hist = '0;
          end else begin
            if ((w.cluster0_freq <= down_khz && w.cluster1_freq <= down_khz) ||
                down_task_floor >= w.runnable_tasks) begin
              if (down_hist == HIST_MAX) saturated++;
              else down_hist++;
              up_hist = '0;
            end else if (w.cluster0_freq >= up_freq || w.cluster1_freq >= up_freq) begin
              if (up_hist == HIST_MAX) saturated++;
              else up_hist++;
              down_hist = '0;
            end
            if (up_hist > up_limit) verdict = VERDICT_UP;
            else if (down_hist > down_limit) verdict = VERDICT_DOWN;
          end
          if (verdict == VERDICT_DOWN) begin
            down_votes++;
            move_toward(lvl < int'(LEVEL_TOP) ? lvl + 1 : int'(LEVEL_TOP), 1'b0, r);
          end else if (verdict == VERDICT_UP) begin
            up_votes++;
            // At half the cores a light task load keeps the level where it is.
            if (level == LEVEL_HALF && up_task_floor >= w.runnable_tasks)
              move_toward(lvl, 1'b0, r);
            else
              move_toward(lvl > int'(LEVEL_ALL) ? lvl - 1 : int'(LEVEL_ALL), 1'b0, r);
          end
        end
        KIND_DISPLAY_OFF: begin
          display_on = 1'b0;
          move_toward(lvl < int'(LEVEL_TOP) ? lvl + 1 : int'(LEVEL_TOP), 1'b0, r);
        end
        KIND_DISPLAY_ON: begin
          display_on = 1'b1;
          move_toward(LEVEL_HALF, 1'b1, r);
        end
        KIND_SUSPEND: begin
          suspended = 1'b1;
          up_hist   = '0;
          down_hist = '0;
        end
        KIND_RESUME: suspended = 1'b0;
        default: ;
      endcase
      r.level    = level;
      r.decision = verdict;
      due_results.push_back(r);
    endfunction

    function void check_field(string name, logic [7:0] expv, logic [7:0] actv);
      if (expv !== actv) begin
        $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
        failures++;
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $error("result word with nothing expected: level %0d", got.level);
        failures++;
        return;
      end
      want = due_results.pop_front();
      check_field("level", 8'(want.level), 8'(got.level));
      check_field("level_changed", 8'(want.level_changed), 8'(got.level_changed));
      check_field("adding_cores", 8'(want.adding_cores), 8'(got.adding_cores));
      check_field("core_delta", 8'(want.core_delta), 8'(got.core_delta));
      check_field("decision", 8'(want.decision), 8'(got.decision));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   idling_on;
  int   sink_stall = 0;
  level_scoreboard sb;

  chlg_in_if  samples_if();
  chlg_out_if results_if();
  chlg_cfg_if cfg_if();

  core_hotplug_level_governor dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  always #1 clk = ~clk;

  // Result side: every word taken at a clock edge is checked, then ready for the
  // next edge is chosen. Stalls come in random bursts while idling is on.
  always @(posedge clk) begin
    result_t got;
    if (!rst && results_if.valid && results_if.ready) begin
      got.level         = results_if.level;
      got.level_changed = results_if.level_changed;
      got.adding_cores  = results_if.adding_cores;
      got.core_delta    = results_if.core_delta;
      got.decision      = results_if.decision;
      sb.check_word(got);
    end
    if (sink_stall > 0) begin
      sink_stall = sink_stall - 1;
      results_if.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      sink_stall = $urandom_range(0, 15);
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= 1'b1;
    end
  end

  // Frequencies picked against the governor's current thresholds, so that most
  // ticks land in the busy or idle bands and the histories really build up.
  function logic [FREQ_W-1:0] busy_freq();
    case ($urandom_range(0, 5))
      0:       return sb.up_freq;
      1:       return FREQ_TOP;
      default: return FREQ_W'($urandom_range(FREQ_TOP, sb.up_freq));
    endcase
  endfunction

  function logic [FREQ_W-1:0] idle_freq();
    case ($urandom_range(0, 5))
      0:       return sb.down_khz;
      1:       return '0;
      default: return FREQ_W'($urandom_range(sb.down_khz, 0));
    endcase
  endfunction

  function logic [FREQ_W-1:0] mid_freq();
    if (sb.up_freq > sb.down_khz + 1)
      return FREQ_W'($urandom_range(sb.up_freq - 1, sb.down_khz + 1));
    return FREQ_W'($urandom);
  endfunction

  // Task counts above the down floor, and now and then right around the up floor
  // so that the half-cores hold is hit from both sides.
  function logic [TASK_W-1:0] busy_tasks();
    int t;
    if ($urandom_range(0, 3) == 0) t = int'(sb.up_task_floor) + $urandom_range(0, 2) - 1;
    else t = $urandom_range(TASK_TOP, sb.down_task_floor + 1);
    if (t < 0) t = 0;
    if (t > TASK_TOP) t = TASK_TOP;
    return TASK_W'(t);
  endfunction

  // Offers one word and returns at the edge where it is taken; valid stays high
  // so a following word can go out back to back.
  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [FREQ_W-1:0] c0,
                           input logic [FREQ_W-1:0] c1, input logic [TASK_W-1:0] nr);
    item_t w;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      samples_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    w.kind           = kind;
    w.cluster0_freq  = c0;
    w.cluster1_freq  = c1;
    w.runnable_tasks = nr;
    samples_if.valid          <= 1'b1;
    samples_if.kind           <= w.kind;
    samples_if.cluster0_freq  <= w.cluster0_freq;
    samples_if.cluster1_freq  <= w.cluster1_freq;
    samples_if.runnable_tasks <= w.runnable_tasks;
    do @(posedge clk); while (!samples_if.ready);
    sb.note_word(w);
  endtask

  task automatic send_tick(input logic [FREQ_W-1:0] c0, input logic [FREQ_W-1:0] c1,
                           input logic [TASK_W-1:0] nr);
    send_word(KIND_TICK, c0, c1, nr);
  endtask

  // Non-tick words carry random payloads, which the governor must ignore.
  task automatic send_event(input logic [KIND_W-1:0] kind);
    send_word(kind, FREQ_W'($urandom), FREQ_W'($urandom), TASK_W'($urandom));
  endtask

  // Lowers valid and waits for every expected word.
  task automatic drain_results();
    int waited;
    waited = 0;
    samples_if.valid <= 1'b0;
    while (sb.due_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.note_setting(idx, data);
  endtask

  // Rewrites all eight registers once the governor has gone quiet.
  task automatic program_settings(input logic [CFG_DATA_W-1:0] up_f, down_f, up_l, down_l,
                                  input logic [CFG_DATA_W-1:0] up_t, down_t, fewest, most);
    drain_results();
    write_reg(REG_UP_FREQUENCY, up_f);
    write_reg(REG_DOWN_FREQUENCY, down_f);
    write_reg(REG_UP_LIMIT, up_l);
    write_reg(REG_DOWN_LIMIT, down_l);
    write_reg(REG_UP_TASK_FLOOR, up_t);
    write_reg(REG_DOWN_TASK_FLOOR, down_t);
    write_reg(REG_FEWEST_LOCK, fewest);
    write_reg(REG_MOST_LOCK, most);
    cfg_if.valid <= 1'b0;
  endtask

  // Random traffic: runs of ticks of one flavor (busy, idle by frequency, idle by
  // task count, mid band, or anything at all), broken up by display, suspend,
  // resume and unknown-kind words.
  task automatic random_words(input int count);
    int sent, mode, run, r;
    logic [FREQ_W-1:0] c0, c1;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 15) begin
        r = $urandom_range(0, 99);
        if (r < 28)      send_event(KIND_DISPLAY_OFF);
        else if (r < 52) send_event(KIND_DISPLAY_ON);
        else if (r < 64) send_event(KIND_SUSPEND);
        else if (r < 88) send_event(KIND_RESUME);
        else             send_event(KIND_W'(KIND_RESUME + $urandom_range(1, 3)));
        sent++;
      end else begin
        r = $urandom_range(0, 99);
        mode = (r < 35) ? 0 : (r < 65) ? 1 : (r < 75) ? 2 : (r < 85) ? 3 : 4;
        run = $urandom_range(1, 10);
        repeat (run) begin
          case (mode)
            0: begin
              c0 = busy_freq();
              c1 = $urandom_range(0, 1) ? busy_freq() : idle_freq();
              if ($urandom_range(0, 1)) send_tick(c0, c1, busy_tasks());
              else send_tick(c1, c0, busy_tasks());
            end
            1: send_tick(idle_freq(), idle_freq(), TASK_W'($urandom));
            2: send_tick(busy_freq(), $urandom_range(0, 1) ? busy_freq() : idle_freq(),
                         TASK_W'($urandom_range(sb.down_task_floor, 0)));
            3: send_tick(mid_freq(), FREQ_W'($urandom), TASK_W'($urandom));
            default: send_tick(FREQ_W'($urandom), FREQ_W'($urandom), TASK_W'($urandom));
          endcase
          sent++;
        end
      end
    end
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    idling_on = 1'b1;
    samples_if.valid          <= 1'b0;
    samples_if.kind           <= KIND_TICK;
    samples_if.cluster0_freq  <= '0;
    samples_if.cluster1_freq  <= '0;
    samples_if.runnable_tasks <= '0;
    cfg_if.valid              <= 1'b0;
    cfg_if.index              <= REG_UP_FREQUENCY;
    cfg_if.data               <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset settings. Field extremes first, then a climb to
    // half the cores under the display cap, a display-off step down, an up move,
    // the half-cores hold on a light load, the top level with the display off, a
    // suspended stretch where nothing may move, and unknown kinds.
    send_tick(FREQ_TOP, FREQ_TOP, TASK_W'(TASK_TOP));
    send_tick('0, '0, '0);
    send_tick(FREQ_W'(1000000), '0, TASK_W'(100));
    repeat (5) send_tick(RST_DOWN_FREQUENCY, '0, TASK_W'(100));
    send_event(KIND_DISPLAY_OFF);
    repeat (5) send_tick(RST_UP_FREQUENCY, '0, TASK_W'(TASK_TOP));
    repeat (4) send_tick(RST_UP_FREQUENCY, RST_UP_FREQUENCY, RST_UP_TASK_FLOOR);
    repeat (3) send_event(KIND_DISPLAY_OFF);
    send_event(KIND_SUSPEND);
    send_event(KIND_DISPLAY_ON);
    send_tick(FREQ_TOP, '0, TASK_W'(TASK_TOP));
    send_event(KIND_RESUME);
    send_event(KIND_DISPLAY_ON);
    send_event(KIND_W'(KIND_RESUME + 1));
    send_event(KIND_W'(KIND_RESUME + 3));

    random_words(30);

    // A long busy stretch drives the level to all cores and then pins the up
    // history at its maximum, where it has to stay without wrapping.
    send_event(KIND_RESUME);
    repeat (260) send_tick(FREQ_TOP, FREQ_TOP, TASK_W'(TASK_TOP));

    // Lowest settings; the narrow registers get junk in their unused upper bits,
    // and the locks are off by the all-ones code and by the most negative one.
    program_settings('0, '0, 22'h3FFF00, '0, 22'h3F0000, '0, 22'h3FFFFF, 22'd4);
    random_words(30);

    // Highest settings with both locks at the top level.
    program_settings(FREQ_TOP, FREQ_TOP, 22'd255, 22'd254, 22'(TASK_TOP), 22'(TASK_TOP),
                     22'd3, 22'd3);
    random_words(30);

    // Locks that squeeze the level between half the cores and two cores.
    program_settings(22'd1000000, 22'd600000, 22'd1, 22'd0, 22'd2, 22'd1, 22'd2, 22'd1);
    random_words(30);

    // Back to the reset thresholds with the most-cores lock at zero, which leaves it
    // off. With the display on, an idle stretch can only climb to half the cores.
    program_settings(22'(RST_UP_FREQUENCY), 22'(RST_DOWN_FREQUENCY), 22'(RST_UP_LIMIT),
                     22'(RST_DOWN_LIMIT), 22'(RST_UP_TASK_FLOOR), 22'(RST_DOWN_TASK_FLOOR),
                     22'd7, 22'd0);
    send_event(KIND_RESUME);
    send_event(KIND_DISPLAY_ON);
    repeat (20) send_tick('0, '0, '0);
    random_words(30);

    // Random settings, thresholds possibly crossed, and full speed on both sides.
    program_settings(CFG_DATA_W'($urandom_range(2000000, 500000)),
                     CFG_DATA_W'($urandom_range(1200000, 100000)),
                     CFG_DATA_W'($urandom_range(0, 6)), CFG_DATA_W'($urandom_range(0, 6)),
                     CFG_DATA_W'($urandom_range(0, 20)), CFG_DATA_W'($urandom_range(0, 20)),
                     CFG_DATA_W'($urandom_range(0, 7)), CFG_DATA_W'($urandom_range(0, 7)));
    idling_on = 1'b0;
    random_words(40);

    drain_results();
    if (sb.due_results.size() != 0) begin
      $error("%0d expected result words never arrived", sb.due_results.size());
      sb.failures++;
    end
    $display("Covered %0d sample words, %0d register writes and %0d level moves.",
             sb.words, sb.writes, sb.moves);
    $display("Ticks voted %0d times for more cores and %0d for fewer; %0d met a full history.",
             sb.up_votes, sb.down_votes, sb.saturated);
    if (sb.failures == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
